// ----- src/mact_pkg.sv -----
// Shared types, sizes and calibration tables for the moving-average calibration block.
`default_nettype none
package mact_pkg;

  // Sizes
  localparam int WINDOW       = 8;
  localparam int TABLE_POINTS = 17;
  localparam int SAMPLE_BITS  = 10;
  localparam int FORCE_W      = 16;

  localparam int POS_W      = $clog2(WINDOW);
  localparam int RING_IDX_W = $clog2(2 * WINDOW);
  localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW);
  localparam int TAB_IDX_W  = $clog2(TABLE_POINTS);
  localparam int CAL_IDX_W  = $clog2(2 * TABLE_POINTS);
  localparam int DIFF_W     = FORCE_W + 1;
  localparam int OFS_W      = SAMPLE_BITS + 1;
  localparam int PROD_W     = DIFF_W + OFS_W;
  localparam int QUOT_W     = FORCE_W;
  localparam int REM_W      = SAMPLE_BITS + 1;
  localparam int STEP_W     = $clog2(QUOT_W);
  localparam int ACC_W      = FORCE_W + 2;

  // Count breakpoints: X table, then Y table
  localparam logic [SAMPLE_BITS-1:0] CAL_COUNTS [2*TABLE_POINTS] = '{
    10'd353, 10'd366, 10'd399, 10'd432, 10'd448, 10'd467, 10'd480, 10'd496, 10'd507,
    10'd520, 10'd535, 10'd548, 10'd567, 10'd583, 10'd617, 10'd648, 10'd661,
    10'd349, 10'd359, 10'd395, 10'd427, 10'd445, 10'd464, 10'd476, 10'd491, 10'd504,
    10'd526, 10'd536, 10'd546, 10'd565, 10'd580, 10'd612, 10'd646, 10'd656
  };

  // Sine of -90..90 degrees in Q1.15, saturated at the ends
  localparam logic signed [FORCE_W-1:0] FORCE_TABLE [TABLE_POINTS] = '{
    -16'sd32768, -16'sd30274, -16'sd23170, -16'sd16384, -16'sd12540, -16'sd8481,
    -16'sd5690,  -16'sd2856,  16'sd0,      16'sd2856,   16'sd5690,   16'sd8481,
    16'sd12540,  16'sd16384,  16'sd23170,  16'sd30274,  16'sd32767
  };

  // Input item
  typedef struct packed {
    logic       channel;
    logic [9:0] sample;
  } sample_item_t;

  // Result item
  typedef struct packed {
    logic                      channel_out;
    logic [9:0]                mean_counts;
    logic signed [FORCE_W-1:0] force_res;
  } result_item_t;

  // Queue entry between front and back
  typedef struct packed {
    logic                   channel;
    logic [SAMPLE_BITS-1:0] mean;
  } mean_item_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_MULT,
    BK_PREP,
    BK_DIVIDE,
    BK_FINISH,
    BK_DONE
  } back_state_t;

endpackage
`default_nettype wire

// ----- src/moving_average_table_calibration_top.sv -----
// Top level of the two-axis moving-average and table calibration block.
//
//   channel  direction  payload         handshake
//   sample   in         sample_item_t   sample_valid / sample_ready
//   result   out        result_item_t   result_valid / result_ready
//
// The front end takes one sample per cycle while the two-entry queue has room.
// Back end per item, which sets the rate: below the table it clamps with no search;
// else it searches the points in order and clamps at or above the last point, or
// forms the product, sets up the divider, runs 16 divider steps and the final sum.
// Reset clears the sample rings, sums, positions, queue and sequencer at once.
// A stalled result holds the back end; the front keeps filling the queue.
`default_nettype none
module moving_average_table_calibration_top
  import mact_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         sample_valid,
  output logic              sample_ready,
  input  wire sample_item_t sample_item,
  output logic              result_valid,
  input  wire logic         result_ready,
  output result_item_t      result_item
);

  logic       push_valid;
  logic       push_ready;
  mean_item_t push_item;
  logic       pop_valid;
  logic       pop_ready;
  mean_item_t pop_item;

  mact_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_item  (sample_item),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  mact_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  mact_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule
`default_nettype wire

// ----- src/mact_front.sv -----
// Front end: per-axis sample rings and running sums, produces the window mean.
`default_nettype none
module mact_front
  import mact_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         sample_valid,
  output logic              sample_ready,
  input  wire sample_item_t sample_item,
  output logic              push_valid,
  input  wire logic         push_ready,
  output mean_item_t        push_item
);

  logic [SAMPLE_BITS-1:0] ring [2*WINDOW];
  logic [SUM_W-1:0]       running_sum [2];
  logic [POS_W-1:0]       ring_position [2];

  logic                   ch;
  logic [SAMPLE_BITS-1:0] smp;
  logic [POS_W-1:0]       pos;
  logic [POS_W-1:0]       pos_next;
  logic [RING_IDX_W-1:0]  slot;
  logic [SUM_W-1:0]       sum_next;
  logic                   xfer;

  // Slot of the oldest sample and updated sum
  always_comb begin
    ch       = sample_item.channel;
    smp      = sample_item.sample[SAMPLE_BITS-1:0];
    pos      = ring_position[ch];
    pos_next = (pos == POS_W'(WINDOW - 1)) ? '0 : pos + 1'b1;
    slot     = RING_IDX_W'(pos) + (ch ? RING_IDX_W'(WINDOW) : '0);
    sum_next = running_sum[ch] - SUM_W'(ring[slot]) + SUM_W'(smp);
  end

  assign sample_ready        = push_ready;
  assign xfer                = sample_valid && sample_ready;
  assign push_valid          = sample_valid;
  assign push_item.channel   = ch;
  assign push_item.mean      = SAMPLE_BITS'(sum_next / WINDOW);

  // Ring, sums and positions
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 2 * WINDOW; k++) ring[k] <= '0;
      for (int k = 0; k < 2; k++) begin
        running_sum[k]   <= '0;
        ring_position[k] <= '0;
      end
    end else if (xfer) begin
      ring[slot]        <= smp;
      running_sum[ch]   <= sum_next;
      ring_position[ch] <= pos_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/mact_queue.sv -----
// Two-entry queue of window means between the front and back ends.
`default_nettype none
module mact_queue
  import mact_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push_valid,
  output logic            push_ready,
  input  wire mean_item_t push_item,
  output logic            pop_valid,
  input  wire logic       pop_ready,
  output mean_item_t      pop_item
);

  mean_item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/mact_back.sv -----
// Back end: table search, product, 16-step divider and result register.
`default_nettype none
module mact_back
  import mact_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       pop_valid,
  output logic            pop_ready,
  input  wire mean_item_t pop_item,
  output logic            result_valid,
  input  wire logic       result_ready,
  output result_item_t    result_item
);

  back_state_t state, state_next;

  logic                      ch, ch_next;
  logic [SAMPLE_BITS-1:0]    mean, mean_next;
  logic [TAB_IDX_W-1:0]      idx, idx_next;
  logic signed [DIFF_W-1:0]  diff, diff_next;
  logic [SAMPLE_BITS-1:0]    ofs, ofs_next;
  logic [SAMPLE_BITS-1:0]    span, span_next;
  logic signed [FORCE_W-1:0] base, base_next;
  logic signed [PROD_W-1:0]  prod, prod_next;
  logic                      neg, neg_next;
  logic [REM_W-1:0]          rem, rem_next;
  logic [QUOT_W-1:0]         num_lo, num_lo_next;
  logic [QUOT_W-1:0]         quot, quot_next;
  logic [STEP_W-1:0]         step, step_next;
  logic signed [FORCE_W-1:0] force_val, force_val_next;

  logic [CAL_IDX_W-1:0]      cal_hi;
  logic [CAL_IDX_W-1:0]      cal_lo;
  logic [CAL_IDX_W-1:0]      cal_head;
  logic [SAMPLE_BITS-1:0]    cnt_hi;
  logic [SAMPLE_BITS-1:0]    cnt_lo;
  logic [PROD_W-1:0]         mag;
  logic [PROD_W-1:0]         numer;
  logic [REM_W:0]            trial;
  logic [REM_W:0]            divisor;
  logic                      qbit;
  logic signed [ACC_W-1:0]   acc;

  // Table lookups for the current search point and the queue head
  always_comb begin
    cal_hi   = CAL_IDX_W'(idx) + (ch ? CAL_IDX_W'(TABLE_POINTS) : '0);
    cal_lo   = cal_hi - 1'b1;
    cal_head = pop_item.channel ? CAL_IDX_W'(TABLE_POINTS) : '0;
    cnt_hi   = CAL_COUNTS[cal_hi];
    cnt_lo   = CAL_COUNTS[cal_lo];
  end

  // Divider step and result sum
  always_comb begin
    mag     = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    numer   = {mag[PROD_W-2:0], 1'b0} + PROD_W'(span);
    trial   = {rem, num_lo[QUOT_W-1]};
    divisor = {1'b0, span, 1'b0};
    qbit    = (trial >= divisor);
    acc     = ACC_W'(base) + (neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot}));
  end

  // Sequencer
  always_comb begin
    state_next     = state;
    ch_next        = ch;
    mean_next      = mean;
    idx_next       = idx;
    diff_next      = diff;
    ofs_next       = ofs;
    span_next      = span;
    base_next      = base;
    prod_next      = prod;
    neg_next       = neg;
    rem_next       = rem;
    num_lo_next    = num_lo;
    quot_next      = quot;
    step_next      = step;
    force_val_next = force_val;
    pop_ready      = 1'b0;
    result_valid   = 1'b0;

    case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          ch_next   = pop_item.channel;
          mean_next = pop_item.mean;
          idx_next  = TAB_IDX_W'(1);
          if (CAL_COUNTS[cal_head] > pop_item.mean) begin
            // below the first point
            force_val_next = FORCE_TABLE[0];
            state_next     = BK_DONE;
          end else begin
            state_next = BK_SEARCH;
          end
        end
      end
      BK_SEARCH: begin
        if (cnt_hi > mean && cnt_hi > cnt_lo) begin
          diff_next  = DIFF_W'(FORCE_TABLE[idx]) - DIFF_W'(FORCE_TABLE[idx - 1'b1]);
          ofs_next   = mean - cnt_lo;
          span_next  = cnt_hi - cnt_lo;
          base_next  = FORCE_TABLE[idx - 1'b1];
          state_next = BK_MULT;
        end else if (idx == TAB_IDX_W'(TABLE_POINTS - 1)) begin
          // at or above the last point
          force_val_next = FORCE_TABLE[TABLE_POINTS-1];
          state_next     = BK_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      BK_MULT: begin
        prod_next  = diff * $signed({1'b0, ofs});
        state_next = BK_PREP;
      end
      BK_PREP: begin
        // rounded quotient: (2|d*o| + w) / 2w, known to fit QUOT_W bits
        neg_next    = prod[PROD_W-1];
        rem_next    = numer[QUOT_W+REM_W-1:QUOT_W];
        num_lo_next = numer[QUOT_W-1:0];
        quot_next   = '0;
        step_next   = '0;
        state_next  = BK_DIVIDE;
      end
      BK_DIVIDE: begin
        rem_next    = qbit ? REM_W'(trial - divisor) : trial[REM_W-1:0];
        num_lo_next = {num_lo[QUOT_W-2:0], 1'b0};
        quot_next   = {quot[QUOT_W-2:0], qbit};
        step_next   = step + 1'b1;
        if (step == STEP_W'(QUOT_W - 1)) state_next = BK_FINISH;
      end
      BK_FINISH: begin
        force_val_next = acc[FORCE_W-1:0];
        state_next     = BK_DONE;
      end
      BK_DONE: begin
        result_valid = 1'b1;
        if (result_ready) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign result_item.channel_out = ch;
  assign result_item.mean_counts = mean;
  assign result_item.force_res   = force_val;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ch        <= ch_next;
    mean      <= mean_next;
    idx       <= idx_next;
    diff      <= diff_next;
    ofs       <= ofs_next;
    span      <= span_next;
    base      <= base_next;
    prod      <= prod_next;
    neg       <= neg_next;
    rem       <= rem_next;
    num_lo    <= num_lo_next;
    quot      <= quot_next;
    step      <= step_next;
    force_val <= force_val_next;
  end

endmodule
`default_nettype wire
